[hw/rtl/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 32;
    localparam int TCNT_W  = 5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SLOT_W-1:0]  slot;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_req_item;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic [SLOT_W-1:0] run_slot;
        logic              idle;
        logic              new_segment;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } t_res_item;

    // Running best candidate and busy tally handed from cell to cell.
    typedef struct packed {
        logic               found;
        logic [PRIO_W-1:0]  prio;
        logic [SLOT_W-1:0]  idx;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               last;
        logic [1:0]         busy;
    } t_carry;

    // Slot write and decrement commands broadcast to all cells.
    typedef struct packed {
        logic               load;
        logic               dec;
        logic [SLOT_W-1:0]  slot;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_cell_ctl;

endpackage

[hw/rtl/pps_stream_if.sv]
// Valid and ready channel interface carrying one payload item.
interface pps_stream_if #(parameter type t_payload = logic);

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[hw/rtl/pps_cell.sv]
// One task slot cell of the scheduler chain with its candidate compare stage.
module pps_cell #(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pps_pkg::t_cell_ctl           i_ctl,
    input  logic [pps_pkg::TIME_W-1:0]   i_now,
    input  logic [pps_pkg::TCNT_W-1:0]   i_task_count,
    input  pps_pkg::t_carry              i_carry,
    output pps_pkg::t_carry              o_carry
);

    logic [pps_pkg::ARR_W-1:0]   r_arrival;
    logic [pps_pkg::BURST_W-1:0] r_burst;
    logic [pps_pkg::BURST_W-1:0] r_remaining;
    logic [pps_pkg::PRIO_W-1:0]  r_prio;
    pps_pkg::t_carry             r_carry;
    pps_pkg::t_carry             n_carry;

    logic hit;
    logic in_use;
    logic has_work;
    logic arrived;
    logic take;

    assign hit      = (int'(i_ctl.slot) == IDX);
    assign in_use   = (IDX < int'(i_task_count));
    assign has_work = in_use && (r_remaining != '0);
    assign arrived  = (i_now[pps_pkg::TIME_W-1:pps_pkg::ARR_W] != '0) ||
                      (r_arrival <= i_now[pps_pkg::ARR_W-1:0]);
    assign take     = has_work && arrived && (!i_carry.found || (r_prio < i_carry.prio));

    always_comb begin
        n_carry = i_carry;
        if (take) begin
            n_carry.found   = 1'b1;
            n_carry.prio    = r_prio;
            n_carry.idx     = pps_pkg::SLOT_W'(IDX);
            n_carry.arrival = r_arrival;
            n_carry.burst   = r_burst;
            n_carry.last    = (r_remaining == pps_pkg::BURST_W'(1));
        end
        if (has_work && (i_carry.busy != 2'd2)) begin
            n_carry.busy = i_carry.busy + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_carry     <= '0;
        end else begin
            r_carry <= n_carry;
            if (i_ctl.load && hit) begin
                r_remaining <= i_ctl.burst;
            end else if (i_ctl.dec && hit) begin
                r_remaining <= r_remaining - pps_pkg::BURST_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && hit) begin
            r_arrival <= i_ctl.arrival;
            r_burst   <= i_ctl.burst;
            r_prio    <= i_ctl.prio;
        end
    end

    assign o_carry = r_carry;

endmodule

[hw/rtl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler built on a chain of slot cells.
//
// Channel   Direction  Carries                                   Transfer when
// i_req     in         load of one task slot or one time tick    valid && ready
// o_res     out        one scheduling result per tick            valid && ready
// i_cfg_*   in         number of task slots in use               i_cfg_we high
//
// A load is taken while the scheduler is idle. A tick is accepted, then scanned by a
// wave through each cell in turn, then passes the pick, turnaround and waiting steps.
// The result of a tick is written to the output register in its waiting step.
// Reset clears time, run history and the remaining work of every slot.
// A finished result waits in the output register while the next item is taken;
// the waiting step of the next tick holds until that result is taken.
module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pps_pkg::TCNT_W-1:0]  i_cfg_data,
    pps_stream_if.sink                  i_req,
    pps_stream_if.source                o_res
);

    localparam int CW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_SUB  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                     r_state;
    logic [CW-1:0]                  r_scan_cnt;
    logic [pps_pkg::TCNT_W-1:0]     r_task_count;
    logic [pps_pkg::TIME_W-1:0]     r_now;
    logic [pps_pkg::SLOT_W-1:0]     r_last_run;
    logic                           r_has_run;
    pps_pkg::t_carry                r_win;
    logic [pps_pkg::TIME_W-1:0]     r_start;
    logic [pps_pkg::TIME_W-1:0]     r_comp;
    logic [pps_pkg::TIME_W-1:0]     r_tat;
    logic                           r_new_seg;
    pps_pkg::t_res_item             r_res;
    logic                           r_res_valid;

    pps_pkg::t_cell_ctl             cell_ctl;
    pps_pkg::t_carry                chain [MAX_TASKS+1];
    pps_pkg::t_carry                w;
    pps_pkg::t_req_item             req;
    pps_pkg::t_res_item             n_res;
    logic [pps_pkg::TIME_W-1:0]     now_inc;
    logic [pps_pkg::TIME_W-1:0]     burst_ext;
    logic                           req_xfer;
    logic                           out_load;

    assign req      = i_req.data;
    assign req_xfer = i_req.valid && i_req.ready;
    assign w        = chain[MAX_TASKS];
    assign now_inc  = (r_now == '1) ? r_now : r_now + pps_pkg::TIME_W'(1);
    assign out_load = (r_state == ST_OUT) && (!r_res_valid || o_res.ready);

    assign chain[0] = '0;

    always_comb begin
        cell_ctl         = '0;
        cell_ctl.load    = req_xfer && (req.req_type == pps_pkg::REQ_LOAD);
        cell_ctl.dec     = (r_state == ST_PICK) && w.found;
        cell_ctl.slot    = (r_state == ST_PICK) ? w.idx : req.slot;
        cell_ctl.arrival = req.arrival;
        cell_ctl.burst   = req.burst;
        cell_ctl.prio    = req.prio;
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        pps_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_now        (r_now),
            .i_task_count (r_task_count),
            .i_carry      (chain[g]),
            .o_carry      (chain[g+1])
        );
    end

    assign burst_ext = {{(pps_pkg::TIME_W-pps_pkg::BURST_W){1'b0}}, r_win.burst};

    always_comb begin
        n_res           = '0;
        n_res.tick_time = r_start;
        if (!r_win.found) begin
            n_res.idle     = 1'b1;
            n_res.all_done = (r_win.busy == 2'd0);
        end else begin
            n_res.run_slot    = r_win.idx;
            n_res.new_segment = r_new_seg;
            n_res.all_done    = (r_win.busy == 2'd1) && r_win.last;
            if (r_win.last) begin
                n_res.finished        = 1'b1;
                n_res.completion_time = r_comp;
                n_res.turnaround      = r_tat;
                n_res.waiting         = (r_tat >= burst_ext) ? r_tat - burst_ext : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_cnt   <= '0;
            r_task_count <= '0;
            r_now        <= '0;
            r_last_run   <= '0;
            r_has_run    <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (out_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (req_xfer && (req.req_type == pps_pkg::REQ_TICK)) begin
                        r_scan_cnt <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_scan_cnt <= r_scan_cnt + CW'(1);
                    if (r_scan_cnt == CW'(MAX_TASKS - 1)) begin
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    r_now <= now_inc;
                    if (w.found) begin
                        r_last_run <= w.idx;
                        r_has_run  <= 1'b1;
                    end
                    r_state <= ST_SUB;
                end
                ST_SUB: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PICK) begin
            r_win     <= w;
            r_start   <= r_now;
            r_comp    <= now_inc;
            r_new_seg <= !r_has_run || (r_last_run != w.idx);
        end
        if (r_state == ST_SUB) begin
            r_tat <= r_comp - {{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, r_win.arrival};
        end
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

endmodule

[hw/rtl/pps_checker.sv]
// Port level checks of the preemptive priority scheduler and their binding.
module pps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input pps_pkg::t_res_item  i_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("Result changed while stalled.");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.idle |->
            !i_res.finished && !i_res.new_segment && (i_res.run_slot == '0))
        else $error("Idle tick reports a run.");

    a_comp_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.finished && (i_res.tick_time != '1) |->
            i_res.completion_time == i_res.tick_time + 32'd1)
        else $error("Completion time does not follow the tick time.");

    a_unfinished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res.finished |->
            (i_res.completion_time == '0) && (i_res.turnaround == '0) &&
            (i_res.waiting == '0))
        else $error("Timing figures present without completion.");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.finished |-> i_res.waiting <= i_res.turnaround)
        else $error("Waiting time exceeds turnaround.");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.data)
);
